/* rtl/core/cnbb_pkg.sv */
// Shared types, constants and the reciprocal table of the cross box blur unit.
// No dependencies; imported by the top level.
package cnbb_pkg;

	localparam int CFG_W_BITS  = 12;  // image_width register width
	localparam int CFG_H_BITS  = 16;  // image_height register width
	localparam int CFG_D_BITS  = 16;  // configuration write data width
	localparam int CH_W        = 8;
	localparam int PIX_W       = 3 * CH_W;
	localparam int SUM_W       = 11;  // five samples of 255 at most
	localparam int RECIP_W     = 17;
	localparam int RECIP_SHIFT = 16;
	localparam int PROD_W      = SUM_W + RECIP_W;

	typedef enum logic {
		KIND_PIXEL = 1'b0,
		KIND_DRAIN = 1'b1
	} kind_t;

	typedef enum logic {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} reg_index_t;

	typedef logic [SUM_W-1:0] sum_t;
	typedef logic [PROD_W-1:0] prod_t;

	// ceil(2^16 / n): floor(s * recip(n) >> 16) is exact for s < 2048
	function automatic logic [RECIP_W-1:0] recip(input logic [2:0] n);
		logic [RECIP_W-1:0] r;
		case (n)
			3'd1: r = 17'd65536;
			3'd2: r = 17'd32768;
			3'd3: r = 17'd21846;
			3'd4: r = 17'd16384;
			3'd5: r = 17'd13108;
			default: r = 17'd0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/core/cnbb_div.sv */
// Restoring divider, one quotient bit per cycle.
// Self-contained; used by the top level to rebuild the column/row position.
module cnbb_div #(
	parameter int DIVIDEND_W = 27,
	parameter int DIVISOR_W  = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient,
	output logic [DIVISOR_W-1:0]  remainder
);

	localparam int CW = $clog2(DIVIDEND_W + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CW-1:0]         cnt_q;
	logic [DIVIDEND_W-1:0] dvd_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W:0]    trial;
	logic                  fits;

	assign trial = {rem_q, dvd_q[DIVIDEND_W-1]};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIVIDEND_W-2:0], fits};
			rem_q <= fits ? DIVISOR_W'(trial - {1'b0, divisor}) : DIVISOR_W'(trial);
		end
	end

	assign done      = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;

endmodule

/* rtl/core/cross_neighbour_box_blur_unit.sv */
// Top level of the five-point cross box blur over a raster RGB stream.
// Depends on cnbb_pkg and cnbb_div.
//
// Pixels enter in raster order; the output for pixel p leaves when pixel p+width
// arrives, and drain beats flush the last row. Original pixels sit in one line
// store of 2*MAX_WIDTH entries with a single synchronous read port, so a beat
// that produces an output passes through five reads of the store, one by one,
// then the reciprocal multiply and the output load, plus any wait on out_ready;
// a pixel beat with no output, and any ignored beat, is taken without leaving
// the idle state. After reset, and after a configuration write that leaves the
// frame open, a bit-serial divider rebuilds the column and row of the next
// output while the input stalls; a write that closes the frame stalls it only
// for the size check. The store is not cleared and needs no clearing pass.
module cross_neighbour_box_blur_unit #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        cfg_index,
	input  logic [cnbb_pkg::CFG_D_BITS-1:0] cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        kind,
	input  logic [cnbb_pkg::CH_W-1:0]   red_in,
	input  logic [cnbb_pkg::CH_W-1:0]   green_in,
	input  logic [cnbb_pkg::CH_W-1:0]   blue_in,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [cnbb_pkg::CH_W-1:0]   red_out,
	output logic [cnbb_pkg::CH_W-1:0]   green_out,
	output logic [cnbb_pkg::CH_W-1:0]   blue_out,
	output logic                        frame_end
);

	import cnbb_pkg::*;

	localparam int DEPTH = 2 * MAX_WIDTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int CNT_W = $clog2(MAX_WIDTH * 65535 + 1);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_CHECK,
		ST_DIV,
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_PUT
	} state_t;

	state_t state_q;

	logic [CFG_W_BITS-1:0] width_q;
	logic [CFG_H_BITS-1:0] height_q;
	logic [CNT_W-1:0]      total_q;
	logic [CNT_W-1:0]      accepted_q;
	logic [CNT_W-1:0]      emitted_q;
	logic [AW-1:0]         acc_addr_q;
	logic [AW-1:0]         emit_addr_q;
	logic [CFG_W_BITS-1:0] x_q;
	logic [CNT_W-1:0]      y_q;

	logic                  is_px_q;
	logic                  use_arr_q;
	logic [4:0]            en_q;      // center, up, down, left, right
	logic [2:0]            n_q;
	logic [2:0]            slot_q;
	logic [PIX_W-1:0]      px_q;
	sum_t                  sum_q [3];
	prod_t                 prod_q [3];

	logic                  out_valid_q;
	logic [CH_W-1:0]       red_q, green_q, blue_q;
	logic                  frame_end_q;

	logic [PIX_W-1:0]      mem [DEPTH];
	logic [PIX_W-1:0]      rd_data_q;
	logic [AW-1:0]         rd_addr;
	logic                  wr_en;
	logic [PIX_W-1:0]      wr_data;

	// effective sizes
	logic [CFG_W_BITS-1:0] w_eff;
	logic [CFG_H_BITS-1:0] h_eff;
	logic [27:0]           tot_full;
	logic [AW-1:0]         w_a;

	always_comb begin
		if (width_q == '0)
			w_eff = CFG_W_BITS'(1);
		else if (32'(width_q) > MAX_WIDTH)
			w_eff = CFG_W_BITS'(MAX_WIDTH);
		else
			w_eff = width_q;
		h_eff = (height_q == '0) ? CFG_H_BITS'(1) : height_q;
	end

	assign tot_full = w_eff * h_eff;
	assign w_a      = AW'(w_eff);

	// neighbor addresses modulo the store depth
	logic [AW:0]   up_t, dn_t;
	logic [AW-1:0] up_addr, dn_addr, left_addr, right_addr, acc_addr_nx, emit_addr_nx;

	always_comb begin
		up_t       = {1'b0, emit_addr_q} - {1'b0, w_a};
		up_addr    = up_t[AW] ? AW'(up_t + (AW+1)'(DEPTH)) : up_t[AW-1:0];
		dn_t       = {1'b0, emit_addr_q} + {1'b0, w_a};
		dn_addr    = (dn_t >= (AW+1)'(DEPTH)) ? AW'(dn_t - (AW+1)'(DEPTH)) : dn_t[AW-1:0];
		left_addr  = (emit_addr_q == '0) ? AW'(DEPTH - 1) : emit_addr_q - 1'b1;
		right_addr = (emit_addr_q == AW'(DEPTH - 1)) ? '0 : emit_addr_q + 1'b1;
		emit_addr_nx = right_addr;
		acc_addr_nx  = (acc_addr_q == AW'(DEPTH - 1)) ? '0 : acc_addr_q + 1'b1;
	end

	// decisions for the beat at the input
	logic [CNT_W:0] emit_plus_w;
	logic           acc_full, need_emit, drain_ok, at_down, up_ok, dn_ok, left_ok, right_ok;
	logic           in_fire, cfg_fire, put_fire, px_write_idle;
	logic [PIX_W-1:0] px_in;

	assign emit_plus_w = {1'b0, emitted_q} + (CNT_W+1)'(w_eff);
	assign acc_full    = accepted_q >= total_q;
	assign need_emit   = {1'b0, accepted_q} >= emit_plus_w;
	assign drain_ok    = acc_full && (emitted_q < total_q);
	assign at_down     = {1'b0, accepted_q} == emit_plus_w;
	assign up_ok       = y_q != '0;
	assign dn_ok       = ((CNT_W+1)'(y_q) + 1'b1) < (CNT_W+1)'(h_eff);
	assign left_ok     = x_q != '0;
	assign right_ok    = ({1'b0, x_q} + 1'b1) < {1'b0, w_eff};
	assign px_in       = {blue_in, green_in, red_in};

	assign cfg_ready = state_q == ST_IDLE;
	assign in_ready  = (state_q == ST_IDLE) && !cfg_valid;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign in_fire   = in_valid && in_ready;
	assign put_fire  = (state_q == ST_PUT) && (!out_valid_q || out_ready);

	assign px_write_idle = in_fire && (kind == KIND_PIXEL) && !acc_full && !need_emit;
	assign wr_en   = px_write_idle || (put_fire && is_px_q);
	assign wr_data = (state_q == ST_IDLE) ? px_in : px_q;

	always_comb begin
		case (slot_q)
			3'd0: rd_addr = emit_addr_q;
			3'd1: rd_addr = up_addr;
			3'd2: rd_addr = dn_addr;
			3'd3: rd_addr = left_addr;
			3'd4: rd_addr = right_addr;
			default: rd_addr = emit_addr_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[acc_addr_q] <= wr_data;
		rd_data_q <= mem[rd_addr];
	end

	// divider for column and row of the next output
	logic            div_start, div_done;
	logic [CNT_W-1:0]      div_quot;
	logic [CFG_W_BITS-1:0] div_rem;

	assign div_start = (state_q == ST_CHECK) && (emitted_q < total_q);

	cnbb_div #(
		.DIVIDEND_W(CNT_W),
		.DIVISOR_W (CFG_W_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (emitted_q),
		.divisor  (w_eff),
		.done     (div_done),
		.quotient (div_quot),
		.remainder(div_rem)
	);

	// sample picked for the slot whose read data is back
	logic [PIX_W-1:0] sample;
	logic [2:0]       prev_slot;
	assign prev_slot = slot_q - 1'b1;
	assign sample    = (prev_slot == 3'd2 && use_arr_q) ? px_q : rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			width_q     <= CFG_W_BITS'(640);
			height_q    <= CFG_H_BITS'(480);
			total_q     <= '0;
			accepted_q  <= '0;
			emitted_q   <= '0;
			acc_addr_q  <= '0;
			emit_addr_q <= '0;
			x_q         <= '0;
			y_q         <= '0;
			slot_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (put_fire)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_INIT: begin
					total_q <= CNT_W'(tot_full);
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (emitted_q >= total_q) begin
						accepted_q  <= '0;
						emitted_q   <= '0;
						acc_addr_q  <= '0;
						emit_addr_q <= '0;
						x_q         <= '0;
						y_q         <= '0;
						state_q     <= ST_IDLE;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						x_q     <= div_rem;
						y_q     <= div_quot;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cfg_fire) begin
						case (reg_index_t'(cfg_index))
							REG_IMAGE_WIDTH:  width_q  <= cfg_data[CFG_W_BITS-1:0];
							REG_IMAGE_HEIGHT: height_q <= cfg_data[CFG_H_BITS-1:0];
							default: ;
						endcase
						state_q <= ST_INIT;
					end else if (in_fire) begin
						if (px_write_idle) begin
							accepted_q <= accepted_q + 1'b1;
							acc_addr_q <= acc_addr_nx;
						end else if ((kind == KIND_PIXEL && !acc_full) ||
								(kind == KIND_DRAIN && drain_ok)) begin
							state_q <= ST_READ;
							slot_q  <= '0;
						end
					end
				end
				ST_READ: begin
					slot_q <= slot_q + 1'b1;
					if (slot_q == 3'd5)
						state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_PUT;
				end
				ST_PUT: begin
					if (put_fire) begin
						// last output of the frame: start over
						if ({1'b0, emitted_q} + 1'b1 >= {1'b0, total_q}) begin
							accepted_q  <= '0;
							emitted_q   <= '0;
							acc_addr_q  <= '0;
							emit_addr_q <= '0;
							x_q         <= '0;
							y_q         <= '0;
						end else begin
							emitted_q   <= emitted_q + 1'b1;
							emit_addr_q <= emit_addr_nx;
							if (!right_ok) begin
								x_q <= '0;
								y_q <= y_q + 1'b1;
							end else begin
								x_q <= x_q + 1'b1;
							end
							if (is_px_q) begin
								accepted_q <= accepted_q + 1'b1;
								acc_addr_q <= acc_addr_nx;
							end
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_INIT;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_fire) begin
			is_px_q   <= kind == KIND_PIXEL;
			use_arr_q <= (kind == KIND_PIXEL) && at_down;
			en_q      <= {right_ok, left_ok, dn_ok, up_ok, 1'b1};
			n_q       <= 3'd1 + 3'(up_ok) + 3'(dn_ok) + 3'(left_ok) + 3'(right_ok);
			px_q      <= px_in;
			for (int c = 0; c < 3; c++)
				sum_q[c] <= '0;
		end else if (state_q == ST_READ && slot_q != 3'd0) begin
			if (en_q[prev_slot])
				for (int c = 0; c < 3; c++)
					sum_q[c] <= sum_q[c] + SUM_W'(sample[c*CH_W +: CH_W]);
		end
		if (state_q == ST_MUL)
			for (int c = 0; c < 3; c++)
				prod_q[c] <= sum_q[c] * recip(n_q);
		if (put_fire) begin
			red_q       <= prod_q[0][RECIP_SHIFT +: CH_W];
			green_q     <= prod_q[1][RECIP_SHIFT +: CH_W];
			blue_q      <= prod_q[2][RECIP_SHIFT +: CH_W];
			frame_end_q <= ({1'b0, emitted_q} + 1'b1) == {1'b0, total_q};
		end
	end

	assign out_valid = out_valid_q;
	assign red_out   = red_q;
	assign green_out = green_q;
	assign blue_out  = blue_q;
	assign frame_end = frame_end_q;

	// checks
	a_no_dual_accept: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_fire && cfg_fire))
		else $error("input and configuration beats taken together");

	a_emit_behind_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (emitted_q <= accepted_q))
		else $error("more outputs than accepted pixels");

	a_column_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (x_q < w_eff))
		else $error("column position outside the row");

	a_output_from_put: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_PUT))
		else $error("output loaded outside the output state");

endmodule

/* tb/cnbb_checker.sv */
// Scoreboard for cross_neighbour_box_blur_unit: follows the register, input and output
// channels, predicts each blurred pixel and compares every output beat.
// Depends on cnbb_pkg.
module cnbb_checker #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic                            cfg_index,
	input  logic [cnbb_pkg::CFG_D_BITS-1:0] cfg_data,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic                            kind,
	input  logic [cnbb_pkg::CH_W-1:0]       red_in,
	input  logic [cnbb_pkg::CH_W-1:0]       green_in,
	input  logic [cnbb_pkg::CH_W-1:0]       blue_in,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic [cnbb_pkg::CH_W-1:0]       red_out,
	input  logic [cnbb_pkg::CH_W-1:0]       green_out,
	input  logic [cnbb_pkg::CH_W-1:0]       blue_out,
	input  logic                            frame_end,
	output int                              errors,
	output int                              pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import cnbb_pkg::*;

	localparam int DEPTH = 2 * MAX_WIDTH;

	typedef struct packed {
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] red;
	} rgb_t;

	typedef struct packed {
		rgb_t color;
		logic last;
	} blur_out_t;

	typedef struct {
		int unsigned red;
		int unsigned green;
		int unsigned blue;
	} rgb_sum_t;

	logic [CFG_W_BITS-1:0] width_reg;
	logic [CFG_H_BITS-1:0] height_reg;
	rgb_t                  line_mem [DEPTH];
	logic [26:0]           taken;
	logic [26:0]           given;
	blur_out_t             blurred_q [$];
	blur_out_t             oldest;

	function automatic int unsigned row_len();
		int unsigned w;
		w = width_reg;
		if (w == 0)
			w = 1;
		if (w > MAX_WIDTH)
			w = MAX_WIDTH;
		return w;
	endfunction

	function automatic int unsigned row_count();
		return (height_reg == 0) ? 1 : height_reg;
	endfunction

	function automatic rgb_sum_t add_rgb(input rgb_sum_t s, input rgb_t c);
		s.red   += c.red;
		s.green += c.green;
		s.blue  += c.blue;
		return s;
	endfunction

	function automatic void check_field(input string name, input logic [CH_W-1:0] want,
	                                    input logic [CH_W-1:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	// blurred output for pixel index `given`; the down neighbour may be the beat arriving now
	task automatic blur_pixel(input int unsigned w, input int unsigned h, input rgb_t arriving,
	                          input bit has_arriving);
		int unsigned p, x, y, n;
		rgb_sum_t    s;
		rgb_t        dn;
		blur_out_t   r;
		p = given;
		x = p % w;
		y = p / w;
		n = 1;
		s = '{default: 0};
		s = add_rgb(s, line_mem[p % DEPTH]);
		if (y > 0) begin
			s = add_rgb(s, line_mem[(p - w) % DEPTH]);
			n++;
		end
		if (y + 1 < h) begin
			dn = (has_arriving && taken == p + w) ? arriving : line_mem[(p + w) % DEPTH];
			s = add_rgb(s, dn);
			n++;
		end
		if (x > 0) begin
			s = add_rgb(s, line_mem[(p - 1) % DEPTH]);
			n++;
		end
		if (x + 1 < w) begin
			s = add_rgb(s, line_mem[(p + 1) % DEPTH]);
			n++;
		end
		r.color.red   = CH_W'(s.red / n);
		r.color.green = CH_W'(s.green / n);
		r.color.blue  = CH_W'(s.blue / n);
		r.last        = (p + 1 == w * h);
		blurred_q.push_back(r);
		given = 27'(p + 1);
	endtask

	task automatic blur_step(input kind_t k, input rgb_t px);
		int unsigned w, h, total;
		w = row_len();
		h = row_count();
		total = w * h;
		// a register write may already have put the frame behind us
		if (given >= total) begin
			taken = '0;
			given = '0;
		end
		if (k == KIND_PIXEL) begin
			if (taken < total) begin
				if (taken >= given + w)
					blur_pixel(w, h, px, 1'b1);
				line_mem[taken % DEPTH] = px;
				taken = taken + 1'b1;
			end
		end else if (taken >= total && given < total) begin
			blur_pixel(w, h, '0, 1'b0);
		end
		if (given >= total) begin
			taken = '0;
			given = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg  = 12'd640;
			height_reg = 16'd480;
			taken      = '0;
			given      = '0;
			blurred_q.delete();
			errors     = 0;
			pending    = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_IMAGE_WIDTH)
					width_reg = cfg_data[CFG_W_BITS-1:0];
				else
					height_reg = cfg_data[CFG_H_BITS-1:0];
			end
			// outputs first: a beat accepted now cannot be answered in the same cycle
			if (out_valid && out_ready) begin
				if (blurred_q.size() == 0) begin
					errors++;
					$display("%0t ns: output beat with none expected, got r=%0d g=%0d b=%0d end=%0b",
					         $time, red_out, green_out, blue_out, frame_end);
				end else begin
					oldest = blurred_q.pop_front();
					check_field("red_out", oldest.color.red, red_out);
					check_field("green_out", oldest.color.green, green_out);
					check_field("blue_out", oldest.color.blue, blue_out);
					check_field("frame_end", CH_W'(oldest.last), CH_W'(frame_end));
				end
			end
			if (in_valid && in_ready)
				blur_step(kind_t'(kind), rgb_t'({blue_in, green_in, red_in}));
			pending = blurred_q.size();
		end
	end

endmodule

/* tb/tb_cross_neighbour_box_blur_unit.sv */
// Testbench top for cross_neighbour_box_blur_unit: clock, reset, frame stimulus and verdict.
// Depends on cnbb_pkg, the unit under test and cnbb_checker.
module tb_cross_neighbour_box_blur_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import cnbb_pkg::*;

	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_ITEMS  = 1500;
	localparam int WIDEST        = 2048;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic                  cfg_index = 1'b0;
	logic [CFG_D_BITS-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  kind = 1'b0;
	logic [CH_W-1:0]       red_in = '0;
	logic [CH_W-1:0]       green_in = '0;
	logic [CH_W-1:0]       blue_in = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [CH_W-1:0]       red_out;
	logic [CH_W-1:0]       green_out;
	logic [CH_W-1:0]       blue_out;
	logic                  frame_end;
	int                    errors;
	int                    pending;
	bit                    gaps_on = 1'b1;
	bit                    hold_armed = 1'b0;
	bit                    hold_done = 1'b0;
	int unsigned           counted = 0;

	cross_neighbour_box_blur_unit uut (.*);
	cnbb_checker chk (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [CH_W-1:0] pick_channel();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return CH_W'($urandom);
		endcase
	endfunction

	task automatic send_beat(input kind_t k, input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
	                         input logic [CH_W-1:0] b);
		while (gaps_on && $urandom_range(0, 99) < 7) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		kind     <= k;
		red_in   <= r;
		green_in <= g;
		blue_in  <= b;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic send_random(input kind_t k);
		send_beat(k, pick_channel(), pick_channel(), pick_channel());
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [CFG_D_BITS-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic set_size(input int unsigned w, input int unsigned h);
		logic [CFG_D_BITS-1:0] word;
		wait_idle();
		// bits above the width field are don't-care, so toggle them
		word = CFG_D_BITS'($urandom);
		word[CFG_W_BITS-1:0] = CFG_W_BITS'(w);
		write_reg(REG_IMAGE_WIDTH, word);
		write_reg(REG_IMAGE_HEIGHT, CFG_D_BITS'(h));
		cfg_valid <= 1'b0;
	endtask

	task automatic play_frame(input int unsigned w, input int unsigned h, input bit noisy);
		int unsigned cols, rows, i;
		cols = (w == 0) ? 1 : ((w > WIDEST) ? WIDEST : w);
		rows = (h == 0) ? 1 : h;
		for (i = 0; i < cols * rows; i++) begin
			// drain before the frame is complete: dropped
			if (noisy && $urandom_range(0, 29) == 0)
				send_random(KIND_DRAIN);
			send_random(KIND_PIXEL);
		end
		// pixel beyond the frame: dropped
		if (noisy)
			send_random(KIND_PIXEL);
		for (i = 0; i < cols; i++)
			send_random(KIND_DRAIN);
		counted += cols * rows + cols;
	endtask

	initial begin : ready_side
		int unsigned n;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_armed && !hold_done) begin
				out_ready <= 1'b0;
				for (n = 1; n < HOLD_CYCLES; n++)
					@(negedge clk);
				hold_done = 1'b1;
			end else begin
				out_ready <= !(gaps_on && $urandom_range(0, 99) < 7);
			end
		end
	end

	initial begin
		#10ms;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		int unsigned i, w, h;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero sizes act as 1x1; early drain, surplus pixel and drain of an empty frame drop
		set_size(0, 0);
		send_random(KIND_DRAIN);
		send_random(KIND_PIXEL);
		send_random(KIND_PIXEL);
		send_random(KIND_DRAIN);
		send_random(KIND_DRAIN);

		// 3x3 with red and green at extreme values: corner, edge and center neighbourhoods
		set_size(3, 3);
		for (i = 0; i < 9; i++)
			send_beat(KIND_PIXEL, i[0] ? 8'hFF : 8'h00, (i % 3 == 1) ? 8'hFF : 8'h00,
			          8'hFF - 8'(i * 29));
		for (i = 0; i < 3; i++)
			send_random(KIND_DRAIN);

		// tallest column left mid-frame, then a frame smaller than what was already emitted
		set_size(1, 16'hFFFF);
		for (i = 0; i < 4; i++)
			send_random(KIND_PIXEL);
		set_size(2, 1);
		play_frame(2, 1, 1'b0);

		// one frame with no idling on either side
		set_size(16, 4);
		gaps_on = 1'b0;
		play_frame(16, 4, 1'b0);
		gaps_on = 1'b1;

		// random frames; the receiver holds off at the start so the input backs up
		w = 8;
		h = 6;
		set_size(w, h);
		hold_armed = 1'b1;
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			play_frame(w, h, $urandom_range(0, 3) == 0);
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 9))
					0: w = 0;
					1: w = 1;
					2: w = $urandom_range(17, 48);
					default: w = $urandom_range(2, 12);
				endcase
				h = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 8);
				set_size(w, h);
			end
		end

		wait_idle();
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
